// ===== design/connection_acl_matcher_assert.svh =====
// Assertion macros shared by the connection ACL matcher RTL.
`ifndef CONNECTION_ACL_MATCHER_ASSERT_SVH
`define CONNECTION_ACL_MATCHER_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked at every rising clock edge outside reset.
`define ACL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("acl matcher: same-cycle check failed");
// Next-cycle implication.
`define ACL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("acl matcher: next-cycle check failed");
`else
`define ACL_ASSERT_NOW(label, clk, rst, ante, cons)
`define ACL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== design/acl_pkg.sv =====
// Shared types and constants for the connection ACL matcher.
package acl_pkg;

   localparam int MaxRulesDefault = 16;

   localparam int AddrW = 64;
   localparam int PortW = 16;
   localparam int V4W   = 32;

   typedef enum logic [1:0] {
      FUNC_ADD   = 2'd0,
      FUNC_CHECK = 2'd1,
      FUNC_CLEAR = 2'd2,
      FUNC_NOP   = 2'd3
   } func_type;

   // rule address kinds
   localparam logic [1:0] KIND_V4  = 2'd0;
   localparam logic [1:0] KIND_V6  = 2'd1;
   localparam logic [1:0] KIND_ANY = 2'd2;

   // connection families
   localparam logic [1:0] FAM_V4 = 2'd1;
   localparam logic [1:0] FAM_V6 = 2'd2;

   // bits 63..32 of the low word of an IPv4-mapped IPv6 address
   localparam logic [V4W-1:0] MAPPED_TAG = 32'h0000_FFFF;

   typedef struct packed {
      logic [AddrW-1:0] upper;
      logic [AddrW-1:0] lower;
      logic [PortW-1:0] port;
      logic [1:0]       kind;
      logic             action;
   } acl_rule_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_FETCH,
      ST_COMPARE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic latch;
      logic add_write;
      logic add_reject;
      logic clear;
      logic scan_start;
      logic fetch;
      logic record_hit;
      logic load_result;
   } cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       inet;
      logic       full;
      logic       empty;
      logic       hit;
      logic       last;
      logic       out_free;
   } status_type;

endpackage

// ===== design/connection_acl_matcher.sv =====
// Top level of the connection ACL matcher.
// First-match access list for outgoing connections. Up to MAX_RULES rules are
// held in a rule memory with one write port and one registered read port, in
// insertion order; position 0 is the newest rule. One transaction is worked at
// a time: an add, a clear or an unused function goes from decode straight to
// done, while a check with an internet family and a non-empty table scans from
// the newest rule until one decides it or all held rules are compared. The scan
// reads one rule per cycle through the registered read
// port of the rule memory and compares it in the next cycle, overlapped with
// the next read. A finished result sits in an output register, so the next
// transaction is taken while the result still waits for the consumer. Reset
// empties the table at once; rule entries are never cleared, only the count.
`include "connection_acl_matcher_assert.svh"

module connection_acl_matcher
   import acl_pkg::*;
#(
   parameter int MAX_RULES = MaxRulesDefault
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [1:0]  req_rule_kind,
   input  logic        req_rule_is_block,
   input  logic [1:0]  req_conn_family,
   input  logic [63:0] req_addr_high,
   input  logic [63:0] req_addr_low,
   input  logic [15:0] req_port_number,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_verdict_block,
   output logic        rsp_rule_matched,
   output logic [3:0]  rsp_match_position,
   output logic        rsp_add_rejected,
   output logic [4:0]  rsp_rules_held
);

   cmd_type    cmd;
   status_type status;

   acl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   acl_datapath #(
      .MAX_RULES (MAX_RULES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_func           (req_func),
      .req_rule_kind      (req_rule_kind),
      .req_rule_is_block  (req_rule_is_block),
      .req_conn_family    (req_conn_family),
      .req_addr_high      (req_addr_high),
      .req_addr_low       (req_addr_low),
      .req_port_number    (req_port_number),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_verdict_block  (rsp_verdict_block),
      .rsp_rule_matched   (rsp_rule_matched),
      .rsp_match_position (rsp_match_position),
      .rsp_add_rejected   (rsp_add_rejected),
      .rsp_rules_held     (rsp_rules_held)
   );

   // checks
   `ACL_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `ACL_ASSERT_NOW(a_no_write_when_full, clock, reset, cmd.add_write, !status.full)
   `ACL_ASSERT_NOW(a_no_result_overwrite, clock, reset, cmd.load_result, !rsp_valid || !rsp_stall)
   `ACL_ASSERT_NOW(a_hit_recorded_on_match, clock, reset, cmd.record_hit, status.hit)

endmodule

// ===== design/acl_ctrl.sv =====
// Controller state machine of the connection ACL matcher.
module acl_ctrl
   import acl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   func_type  func;

   assign func = func_type'(status.func);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (func == FUNC_CHECK && status.inet && !status.empty) begin
               state_in = ST_FETCH;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_FETCH: state_in = ST_COMPARE;
         ST_COMPARE: begin
            if (status.hit || status.last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: cmd.latch = req_valid;
         ST_DECODE: begin
            case (func)
               FUNC_ADD: begin
                  cmd.add_reject = status.full;
                  cmd.add_write  = !status.full;
               end
               FUNC_CLEAR: cmd.clear = 1'b1;
               FUNC_CHECK: cmd.scan_start = status.inet && !status.empty;
               default: ;
            endcase
         end
         ST_FETCH: cmd.fetch = 1'b1;
         ST_COMPARE: begin
            if (status.hit) begin
               cmd.record_hit = 1'b1;
            end else if (!status.last) begin
               cmd.fetch = 1'b1;
            end
         end
         ST_DONE: cmd.load_result = status.out_free;
         default: ;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

// ===== design/acl_datapath.sv =====
// Datapath of the connection ACL matcher: request, rule memory, scan, match and result.
module acl_datapath
   import acl_pkg::*;
#(
   parameter int MAX_RULES = MaxRulesDefault
)
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic [1:0]  req_func,
   input  logic [1:0]  req_rule_kind,
   input  logic        req_rule_is_block,
   input  logic [1:0]  req_conn_family,
   input  logic [63:0] req_addr_high,
   input  logic [63:0] req_addr_low,
   input  logic [15:0] req_port_number,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_verdict_block,
   output logic        rsp_rule_matched,
   output logic [3:0]  rsp_match_position,
   output logic        rsp_add_rejected,
   output logic [4:0]  rsp_rules_held
);

   localparam int IdxW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
   localparam int CntW = $clog2(MAX_RULES + 1);
   localparam logic [CntW-1:0] CountMax = CntW'(MAX_RULES);

   // captured transaction
   logic [1:0]       func_ff;
   logic [1:0]       kind_ff;
   logic             block_ff;
   logic [1:0]       fam_ff;
   logic [AddrW-1:0] hi_ff;
   logic [AddrW-1:0] lo_ff;
   logic [PortW-1:0] port_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         func_ff  <= req_func;
         kind_ff  <= req_rule_kind;
         block_ff <= req_rule_is_block;
         fam_ff   <= req_conn_family;
         hi_ff    <= req_addr_high;
         lo_ff    <= req_addr_low;
         port_ff  <= req_port_number;
      end
   end

   // rule count; rules live in insertion order, newest at count-1
   logic [CntW-1:0] count_ff;
   logic [CntW-1:0] count_in;
   logic [CntW-1:0] count_dec;

   assign count_dec = count_ff - CntW'(1);

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.add_write) begin
         count_in = count_ff + CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // new rule image; IPv4 rules keep only the low 32 address bits
   acl_rule_type new_rule;

   always_comb begin
      new_rule.port   = port_ff;
      new_rule.kind   = kind_ff;
      new_rule.action = block_ff;
      if (kind_ff == KIND_V4) begin
         new_rule.upper = '0;
         new_rule.lower = {{(AddrW-V4W){1'b0}}, lo_ff[V4W-1:0]};
      end else begin
         new_rule.upper = hi_ff;
         new_rule.lower = lo_ff;
      end
   end

   // scan counters
   logic [IdxW-1:0] ptr_ff;
   logic [IdxW-1:0] pos_ff;
   logic [IdxW-1:0] rd_pos_ff;
   logic [CntW-1:0] left_ff;

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         ptr_ff  <= count_dec[IdxW-1:0];
         pos_ff  <= '0;
         left_ff <= count_ff;
      end else if (cmd.fetch) begin
         ptr_ff    <= ptr_ff - IdxW'(1);
         pos_ff    <= pos_ff + IdxW'(1);
         left_ff   <= left_ff - CntW'(1);
         rd_pos_ff <= pos_ff;
      end
   end

   // rule memory: one write port, one registered read port
   acl_rule_type rule_mem [MAX_RULES];
   acl_rule_type rd_rule_ff;

   always_ff @(posedge clock) begin
      if (cmd.add_write) begin
         rule_mem[count_ff[IdxW-1:0]] <= new_rule;
      end
      if (cmd.fetch) begin
         rd_rule_ff <= rule_mem[ptr_ff];
      end
   end

   // match of the fetched rule against the connection
   logic port_ok;
   logic addr_ok;
   logic rule_mapped;
   logic conn_mapped;
   logic v4_equal;

   assign rule_mapped = (rd_rule_ff.upper == '0) &&
                        (rd_rule_ff.lower[AddrW-1:V4W] == MAPPED_TAG);
   assign conn_mapped = (hi_ff == '0) && (lo_ff[AddrW-1:V4W] == MAPPED_TAG);
   assign v4_equal    = (rd_rule_ff.lower == {{(AddrW-V4W){1'b0}}, lo_ff[V4W-1:0]});
   assign port_ok     = (rd_rule_ff.port == '0) || (rd_rule_ff.port == port_ff);

   always_comb begin
      addr_ok = 1'b0;
      case (rd_rule_ff.kind)
         KIND_ANY: addr_ok = 1'b1;
         KIND_V6: begin
            if (fam_ff == FAM_V6) begin
               addr_ok = (rd_rule_ff.upper == hi_ff) && (rd_rule_ff.lower == lo_ff);
            end else begin
               addr_ok = rule_mapped &&
                         (rd_rule_ff.lower[V4W-1:0] == lo_ff[V4W-1:0]);
            end
         end
         KIND_V4: begin
            if (fam_ff == FAM_V4) begin
               addr_ok = v4_equal;
            end else begin
               addr_ok = conn_mapped && v4_equal;
            end
         end
         default: addr_ok = 1'b0;
      endcase
   end

   // per-transaction result
   logic            matched_ff;
   logic            verdict_ff;
   logic [IdxW-1:0] mpos_ff;
   logic            rejected_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         matched_ff  <= 1'b0;
         verdict_ff  <= 1'b0;
         mpos_ff     <= '0;
         rejected_ff <= 1'b0;
      end else begin
         if (cmd.add_reject) rejected_ff <= 1'b1;
         if (cmd.record_hit) begin
            matched_ff <= 1'b1;
            verdict_ff <= rd_rule_ff.action;
            mpos_ff    <= rd_pos_ff;
         end
      end
   end

   // output register
   logic              rsp_valid_ff;
   logic              out_verdict_ff;
   logic              out_matched_ff;
   logic [3:0]        out_pos_ff;
   logic              out_rejected_ff;
   logic [4:0]        out_held_ff;
   logic [IdxW+3:0]   pos_wide;
   logic [CntW+4:0]   held_wide;

   assign pos_wide  = {4'b0, mpos_ff};
   assign held_wide = {5'b0, count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         out_verdict_ff  <= verdict_ff;
         out_matched_ff  <= matched_ff;
         out_pos_ff      <= pos_wide[3:0];
         out_rejected_ff <= rejected_ff;
         out_held_ff     <= held_wide[4:0];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_verdict_block  = out_verdict_ff;
   assign rsp_rule_matched   = out_matched_ff;
   assign rsp_match_position = out_pos_ff;
   assign rsp_add_rejected   = out_rejected_ff;
   assign rsp_rules_held     = out_held_ff;

   // status toward the controller
   assign status.func     = func_ff;
   assign status.inet     = (fam_ff == FAM_V4) || (fam_ff == FAM_V6);
   assign status.full     = (count_ff >= CountMax);
   assign status.empty    = (count_ff == '0);
   assign status.hit      = port_ok && addr_ok;
   assign status.last     = (left_ff == '0);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

endmodule

// ===== test/acl_match_checker.sv =====
`timescale 1ns / 1ps
// Checker that predicts and compares every response of the connection ACL matcher.
module acl_match_checker
   import acl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [1:0]  req_rule_kind,
   input  logic        req_rule_is_block,
   input  logic [1:0]  req_conn_family,
   input  logic [63:0] req_addr_high,
   input  logic [63:0] req_addr_low,
   input  logic [15:0] req_port_number,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_verdict_block,
   input  logic        rsp_rule_matched,
   input  logic [3:0]  rsp_match_position,
   input  logic        rsp_add_rejected,
   input  logic [4:0]  rsp_rules_held,
   output int          errors,
   output int          pending
);

   typedef struct packed {
      logic       verdict_block;
      logic       rule_matched;
      logic [3:0] match_position;
      logic       add_rejected;
      logic [4:0] rules_held;
   } acl_outcome_type;

   // shadow copy of the rule table, position 0 newest
   acl_rule_type    rule_table [MaxRulesDefault];
   int unsigned     rule_count = 0;
   acl_outcome_type outcome_q [$];
   int              mismatch_count = 0;
   int              waiting_count = 0;

   assign errors  = mismatch_count;
   assign pending = waiting_count;

   function automatic logic is_v4_mapped(logic [63:0] hi, logic [63:0] lo);
      return hi == '0 && lo[63:32] == MAPPED_TAG;
   endfunction

   // does one stored rule match the connection?
   function automatic logic rule_fires(acl_rule_type r, logic [1:0] fam, logic [63:0] hi,
                                       logic [63:0] lo, logic [15:0] port);
      if (r.port != '0 && r.port != port)
         return 1'b0;
      case (r.kind)
         KIND_ANY: return 1'b1;
         KIND_V6: begin
            if (fam == FAM_V6)
               return r.upper == hi && r.lower == lo;
            if (is_v4_mapped(r.upper, r.lower))
               return r.lower[31:0] == lo[31:0];
            return 1'b0;
         end
         KIND_V4: begin
            if (fam == FAM_V4 || is_v4_mapped(hi, lo))
               return r.lower == {32'b0, lo[31:0]};
            return 1'b0;
         end
         default: return 1'b0;
      endcase
   endfunction

   // update the shadow table for one transaction and return its outcome
   function automatic acl_outcome_type apply_acl_item(logic [1:0] func, logic [1:0] kind,
                                                      logic blk, logic [1:0] fam,
                                                      logic [63:0] hi, logic [63:0] lo,
                                                      logic [15:0] port);
      acl_outcome_type res;
      acl_rule_type    fresh;
      res = '0;
      case (func)
         FUNC_ADD: begin
            if (rule_count >= MaxRulesDefault) begin
               res.add_rejected = 1'b1;
            end else begin
               for (int j = rule_count; j > 0; j--)
                  rule_table[j] = rule_table[j-1];
               fresh.upper  = (kind == KIND_V4) ? 64'd0 : hi;
               fresh.lower  = (kind == KIND_V4) ? {32'b0, lo[31:0]} : lo;
               fresh.port   = port;
               fresh.kind   = kind;
               fresh.action = blk;
               rule_table[0] = fresh;
               rule_count++;
            end
         end
         FUNC_CHECK: begin
            if (fam == FAM_V4 || fam == FAM_V6) begin
               for (int i = 0; i < rule_count; i++) begin
                  if (rule_fires(rule_table[i], fam, hi, lo, port)) begin
                     res.rule_matched   = 1'b1;
                     res.match_position = 4'(i);
                     res.verdict_block  = rule_table[i].action;
                     break;
                  end
               end
            end
         end
         FUNC_CLEAR: rule_count = 0;
         default: ;
      endcase
      res.rules_held = 5'(rule_count);
      return res;
   endfunction

   task automatic flag_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   // responses are matched first, then the new request is modeled
   always @(posedge clock) begin
      acl_outcome_type want;
      if (reset) begin
         rule_count = 0;
         outcome_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (outcome_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: response with no transaction outstanding", $time);
            end else begin
               want = outcome_q.pop_front();
               flag_field("verdict_block", want.verdict_block, rsp_verdict_block);
               flag_field("rule_matched", want.rule_matched, rsp_rule_matched);
               flag_field("match_position", want.match_position, rsp_match_position);
               flag_field("add_rejected", want.add_rejected, rsp_add_rejected);
               flag_field("rules_held", want.rules_held, rsp_rules_held);
            end
         end
         if (req_valid && !req_stall)
            outcome_q.push_back(apply_acl_item(req_func, req_rule_kind, req_rule_is_block,
                                               req_conn_family, req_addr_high,
                                               req_addr_low, req_port_number));
      end
      waiting_count <= outcome_q.size();
   end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Top-level testbench for the connection ACL matcher: stimulus, flow control and verdict.
module testbench;
   import acl_pkg::*;

   localparam int ItemCount  = 2000;
   localparam int CycleLimit = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func = '0;
   logic [1:0]  req_rule_kind = '0;
   logic        req_rule_is_block = 1'b0;
   logic [1:0]  req_conn_family = '0;
   logic [63:0] req_addr_high = '0;
   logic [63:0] req_addr_low = '0;
   logic [15:0] req_port_number = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_verdict_block;
   logic        rsp_rule_matched;
   logic [3:0]  rsp_match_position;
   logic        rsp_add_rejected;
   logic [4:0]  rsp_rules_held;

   int          fail_count;
   int          in_flight;
   int          cycle_count = 0;
   logic        steady = 1'b0;     // no gaps and no stalls while set
   logic        rsp_taken = 1'b0;
   int          hold_left = 0;

   // address and port pools so checks hit stored rules
   logic [31:0] v4_pool [8];
   logic [63:0] v6_hi_pool [8];
   logic [63:0] v6_lo_pool [8];
   logic [15:0] port_pool [4];

   connection_acl_matcher dut (.*);

   acl_match_checker acl_check (.*, .errors(fail_count), .pending(in_flight));

   always #5 clock = ~clock;

   // consumer: after each accepted response, stall for a random number of cycles
   always @(posedge clock)
      rsp_taken <= rsp_valid && !rsp_stall;

   always @(negedge clock) begin
      if (rsp_taken)
         hold_left = steady ? 0 : $urandom_range(0, 9);
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [15:0] pick_port();
      int k;
      k = $urandom_range(0, 5);
      if (k < 4)
         return port_pool[k];
      return (k == 4) ? 16'($urandom) : 16'd0;
   endfunction

   task automatic refill_pools();
      for (int k = 0; k < 8; k++) begin
         v4_pool[k] = (k == 7) ? 32'hFFFF_FFFF : $urandom;
         if (k % 2 == 0) begin
            v6_hi_pool[k] = '0;
            v6_lo_pool[k] = {MAPPED_TAG, v4_pool[k]};
         end else begin
            v6_hi_pool[k] = rand64();
            v6_lo_pool[k] = rand64();
         end
      end
      port_pool = '{16'd80, 16'd443, 16'($urandom_range(1, 65535)), 16'hFFFF};
   endtask

   // one transaction on the request channel, with a random lead-in gap
   task automatic send_request(input logic [1:0] f, input logic [1:0] kind, input logic blk,
                               input logic [1:0] fam, input logic [63:0] hi,
                               input logic [63:0] lo, input logic [15:0] port);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 9);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_func          <= f;
      req_rule_kind     <= kind;
      req_rule_is_block <= blk;
      req_conn_family   <= fam;
      req_addr_high     <= hi;
      req_addr_low      <= lo;
      req_port_number   <= port;
      req_valid         <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic random_item(int add_pct);
      int          r, k;
      logic [1:0]  kind, fam;
      logic [63:0] hi, lo;
      logic [15:0] port;
      r = $urandom_range(0, 99);
      k = $urandom_range(0, 7);
      if (r < add_pct) begin
         kind = 2'($urandom_range(0, 2));
         if ($urandom_range(0, 29) == 0)
            kind = 2'd3;
         if (kind == KIND_V4) begin
            // upper bits are ignored for an IPv4 rule
            hi = rand64();
            lo = {$urandom, v4_pool[k]};
         end else begin
            hi = v6_hi_pool[k];
            lo = v6_lo_pool[k];
         end
         if ($urandom_range(0, 9) == 0) begin
            hi = rand64();
            lo = rand64();
         end
         port = ($urandom_range(0, 2) == 0) ? 16'd0 : pick_port();
         send_request(FUNC_ADD, kind, 1'($urandom), 2'($urandom), hi, lo, port);
      end else if (r < 93) begin
         fam = 2'($urandom_range(1, 2));
         if ($urandom_range(0, 19) == 0)
            fam = ($urandom_range(0, 1) == 0) ? 2'd0 : 2'd3;
         if (fam == FAM_V4) begin
            hi = ($urandom_range(0, 1) == 0) ? 64'd0 : rand64();
            lo = {($urandom_range(0, 1) == 0) ? 32'd0 : $urandom, v4_pool[k]};
         end else if ($urandom_range(0, 2) == 0) begin
            hi = '0;
            lo = {MAPPED_TAG, v4_pool[k]};
         end else begin
            hi = v6_hi_pool[k];
            lo = v6_lo_pool[k];
         end
         if ($urandom_range(0, 9) == 0) begin
            hi = rand64();
            lo = rand64();
         end
         send_request(FUNC_CHECK, 2'($urandom), 1'($urandom), fam, hi, lo, pick_port());
      end else if (r < 97) begin
         send_request(FUNC_CLEAR, 2'($urandom), 1'($urandom), 2'($urandom), rand64(),
                      rand64(), 16'($urandom));
      end else begin
         send_request(FUNC_NOP, 2'($urandom), 1'($urandom), 2'($urandom), rand64(),
                      rand64(), 16'($urandom));
      end
   endtask

   // watchdog
   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      int add_pct;
      add_pct = 40;
      refill_pools();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty table, non-internet families, no-op
      send_request(FUNC_CHECK, KIND_V4, 1'b0, FAM_V4, '0, 64'h0A00_0001, 16'd80);
      send_request(FUNC_CHECK, KIND_V4, 1'b0, 2'd0, '0, 64'h0A00_0001, 16'd80);
      send_request(FUNC_CHECK, KIND_V4, 1'b0, 2'd3, '0, 64'h0A00_0001, 16'd80);
      send_request(FUNC_NOP, KIND_ANY, 1'b1, FAM_V4, '1, '1, '1);
      // IPv4 rule with junk in the ignored address bits
      send_request(FUNC_ADD, KIND_V4, 1'b1, 2'd3, '1, 64'hFFFF_FFFF_0A00_0001, 16'd80);
      send_request(FUNC_CHECK, KIND_V4, 1'b0, FAM_V4, '1, 64'h1234_5678_0A00_0001, 16'd80);
      send_request(FUNC_CHECK, KIND_V4, 1'b0, FAM_V6, '0, 64'h0000_FFFF_0A00_0001, 16'd80);
      send_request(FUNC_CHECK, KIND_V4, 1'b0, FAM_V6, '0, 64'h0000_FFFE_0A00_0001, 16'd80);
      send_request(FUNC_CHECK, KIND_V4, 1'b0, FAM_V4, '0, 64'h0A00_0001, 16'd81);
      // IPv4-mapped IPv6 rule, any port, hit from an IPv4 connection
      send_request(FUNC_ADD, KIND_V6, 1'b0, FAM_V4, '0, 64'h0000_FFFF_C0A8_0101, 16'd0);
      send_request(FUNC_CHECK, KIND_V4, 1'b0, FAM_V4, '0, 64'hC0A8_0101, 16'd1234);
      // all-ones IPv6 rule
      send_request(FUNC_ADD, KIND_V6, 1'b1, FAM_V6, '1, '1, 16'hFFFF);
      send_request(FUNC_CHECK, KIND_V4, 1'b0, FAM_V6, '1, '1, 16'hFFFF);
      send_request(FUNC_CHECK, KIND_V4, 1'b0, FAM_V4, '1, '1, 16'hFFFF);
      // any-address rule
      send_request(FUNC_ADD, KIND_ANY, 1'b1, FAM_V6, rand64(), rand64(), 16'd443);
      send_request(FUNC_CHECK, KIND_V4, 1'b0, FAM_V6, rand64(), rand64(), 16'd443);
      // unused kind is stored but never matches
      send_request(FUNC_ADD, 2'd3, 1'b1, FAM_V4, '0, '0, 16'd0);
      send_request(FUNC_CHECK, KIND_V4, 1'b0, FAM_V4, '0, '0, 16'd7);
      // fill the table, then one add past full
      repeat (11)
         send_request(FUNC_ADD, KIND_V4, 1'b0, FAM_V4, '0, '0, 16'd1);
      send_request(FUNC_ADD, KIND_V4, 1'b1, FAM_V4, '0, 64'h0A00_0001, 16'd80);
      // oldest rule decides at the last position
      send_request(FUNC_CHECK, KIND_V4, 1'b0, FAM_V4, '0, 64'h0A00_0001, 16'd80);
      send_request(FUNC_CLEAR, KIND_V4, 1'b0, FAM_V4, '0, '0, 16'd0);
      send_request(FUNC_CHECK, KIND_V4, 1'b0, FAM_V4, '0, 64'h0A00_0001, 16'd80);

      // random traffic in phases of varying add density and flow control
      for (int n = 0; n < ItemCount; n++) begin
         if (n % 250 == 0) begin
            refill_pools();
            add_pct = $urandom_range(20, 60);
         end
         if (n % 100 == 0)
            steady = ($urandom_range(0, 3) == 0);
         random_item(add_pct);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      steady = 1'b0;
      while (in_flight != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
